/* design/gwmc_pkg.sv */
package gwmc_pkg;

   // Item actions.
   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_ACCUM = 2'd1;
   localparam logic [1:0] ACT_XFORM = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   // Result error codes.
   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_GROUPS   = 2'd1;
   localparam logic [1:0] ERR_ZERO_DIV = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BETWEEN  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEEP_ALL = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SKIP     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WEIGHTS  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GROUPS   = 3'd4;

   // How the response register is loaded.
   typedef logic [1:0] rsp_kind_type;
   localparam rsp_kind_type RSP_EARLY   = 2'd0;
   localparam rsp_kind_type RSP_ZERO_TW = 2'd1;
   localparam rsp_kind_type RSP_FINAL   = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         latch;
      logic         clr_wr;
      logic         mem_rd;
      logic         acc_upd;
      logic         div_start;
      logic         div_total;
      logic         mean_g_ld;
      logic         mean_t_ld;
      logic         rsp_ld;
      rsp_kind_type rsp_kind;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] action;
      logic       g_ok;
      logic       clr_last;
      logic       early;
      logic       need_total;
      logic       tw_zero;
      logic       div_done;
   } dp_status_type;

endpackage

/* design/gwmc_divider.sv */
module gwmc_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] div_ff, div_in;
   logic [64:0] rem_sh;
   logic [64:0] rem_diff;

   // One restoring step per cycle, 64 steps per division.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      rem_sh   = {rem_ff, quo_ff[63]};
      rem_diff = rem_sh - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (!rem_diff[64]) begin
            rem_in = rem_diff[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* design/gwmc_datapath.sv */
module gwmc_datapath #(
   parameter int unsigned MAX_GROUPS = 1024,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gwmc_pkg::ctrl_cmd_type            cmd,
   output gwmc_pkg::dp_status_type           status,
   input  logic [1:0]                        req_action,
   input  logic [31:0]                       req_sample,
   input  logic                              req_sample_present,
   input  logic [31:0]                       req_weight,
   input  logic                              req_weight_present,
   input  logic [9:0]                        req_group_index,
   output logic                              rsp_valid,
   output logic [31:0]                       rsp_result,
   output logic                              rsp_result_present,
   output logic [1:0]                        rsp_error_code,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gwmc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic                              csr_wdata
);

   localparam int unsigned AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_GROUPS - 1);
   localparam logic signed [35:0] VHI = (36'sd1 <<< (VALUE_BITS - 1)) - 36'sd1;
   localparam logic signed [35:0] VLO = -VHI - 36'sd1;
   localparam logic [63:0] QCAP = 64'd1 << VALUE_BITS;
   localparam logic [63:0] ONE_Q16 = 64'h1_0000;
   localparam logic signed [63:0] SMAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] SMIN = {1'b1, {63{1'b0}}};

   function automatic logic signed [63:0] add_s(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sub_s(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
      return s[63:0];
   endfunction

   function automatic logic [63:0] add_u(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   function automatic logic signed [35:0] sat_v(input logic signed [35:0] v);
      return (v > VHI) ? VHI : ((v < VLO) ? VLO : v);
   endfunction

   // Configuration registers.
   logic between_ff, keep_ff, skip_ff, weights_ff, groups_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         between_ff <= 1'b0;
         keep_ff    <= 1'b0;
         skip_ff    <= 1'b1;
         weights_ff <= 1'b0;
         groups_ff  <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            gwmc_pkg::CSR_BETWEEN:  between_ff <= csr_wdata;
            gwmc_pkg::CSR_KEEP_ALL: keep_ff    <= csr_wdata;
            gwmc_pkg::CSR_SKIP:     skip_ff    <= csr_wdata;
            gwmc_pkg::CSR_WEIGHTS:  weights_ff <= csr_wdata;
            gwmc_pkg::CSR_GROUPS:   groups_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Item capture, with weight and group overrides applied.
   logic [1:0]         act_ff;
   logic signed [31:0] smp_ff;
   logic               s_ok_ff;
   logic [31:0]        w_ff;
   logic               w_ok_ff;
   logic [16:0]        g_ff;
   logic signed [63:0] prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff  <= req_action;
         smp_ff  <= 32'($signed(req_sample[VALUE_BITS-1:0]));
         s_ok_ff <= req_sample_present;
         w_ff    <= weights_ff ? req_weight : 32'(ONE_Q16);
         w_ok_ff <= weights_ff ? req_weight_present : 1'b1;
         g_ff    <= groups_ff ? {7'd0, req_group_index} : 17'd0;
      end
      prod_ff <= 64'($signed(smp_ff) * $signed({1'b0, w_ff}));
   end

   logic          g_ok;
   logic [AW-1:0] addr;
   assign g_ok = (g_ff < 17'(MAX_GROUPS));
   assign addr = g_ff[AW-1:0];

   // Group tables with a registered read and a clearing sweep.
   logic signed [63:0] sum_mem [MAX_GROUPS];
   logic [63:0]        wgt_mem [MAX_GROUPS];
   logic               poi_mem [MAX_GROUPS];
   logic signed [63:0] rd_sum_ff;
   logic [63:0]        rd_wgt_ff;
   logic               rd_poi_ff;
   logic [AW-1:0]      clr_cnt_ff;

   logic               missing;
   logic               mem_we;
   logic [AW-1:0]      wr_addr;
   logic signed [63:0] wr_sum;
   logic [63:0]        wr_wgt;
   logic               wr_poi;

   assign missing = !s_ok_ff || !w_ok_ff;

   always_comb begin
      mem_we  = 1'b0;
      wr_addr = addr;
      wr_sum  = rd_sum_ff;
      wr_wgt  = rd_wgt_ff;
      wr_poi  = rd_poi_ff;
      if (cmd.clr_wr) begin
         mem_we  = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_sum  = '0;
         wr_wgt  = '0;
         wr_poi  = 1'b0;
      end else if (cmd.acc_upd && !rd_poi_ff) begin
         if (missing) begin
            mem_we = !skip_ff;
            wr_poi = 1'b1;
         end else begin
            mem_we = 1'b1;
            wr_sum = add_s(rd_sum_ff, prod_ff);
            wr_wgt = add_u(rd_wgt_ff, {32'd0, w_ff});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[wr_addr] <= wr_sum;
         wgt_mem[wr_addr] <= wr_wgt;
         poi_mem[wr_addr] <= wr_poi;
      end
      if (cmd.mem_rd) begin
         rd_sum_ff <= sum_mem[addr];
         rd_wgt_ff <= wgt_mem[addr];
         rd_poi_ff <= poi_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_cnt_ff <= (clr_cnt_ff == LAST_ADDR) ? '0 : clr_cnt_ff + AW'(1);
      end
   end

   // Overall totals over groups that are not poisoned.
   logic signed [63:0] tot_sum_ff;
   logic [63:0]        tot_wgt_ff;

   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         tot_sum_ff <= '0;
         tot_wgt_ff <= '0;
      end else if (cmd.acc_upd && !rd_poi_ff) begin
         if (missing) begin
            if (!skip_ff) begin
               tot_sum_ff <= sub_s(tot_sum_ff, rd_sum_ff);
               tot_wgt_ff <= (tot_wgt_ff >= rd_wgt_ff) ? tot_wgt_ff - rd_wgt_ff : '0;
            end
         end else begin
            tot_sum_ff <= add_s(tot_sum_ff, prod_ff);
            tot_wgt_ff <= add_u(tot_wgt_ff, {32'd0, w_ff});
         end
      end
   end

   // Early transform outcomes from config, sample and group entry.
   logic       err_groups, miss_out, pois_out, zdiv;
   logic [1:0] early_err;

   assign err_groups = !between_ff && keep_ff && !groups_ff;
   assign miss_out   = !(between_ff && keep_ff) && !s_ok_ff;
   assign pois_out   = g_ok && rd_poi_ff;
   assign zdiv       = !g_ok || (rd_wgt_ff == 64'd0);
   assign early_err  = err_groups ? gwmc_pkg::ERR_GROUPS :
                       ((miss_out || pois_out) ? gwmc_pkg::ERR_OK : gwmc_pkg::ERR_ZERO_DIV);

   // Shared divider for the group mean and the overall mean.
   logic               div_done;
   logic [63:0]        div_q;
   logic signed [63:0] div_num;
   logic [63:0]        div_mag;
   logic               neg_ff;

   assign div_num = cmd.div_total ? tot_sum_ff : rd_sum_ff;
   assign div_mag = div_num[63] ? 64'(-div_num) : 64'(div_num);

   always_ff @(posedge clock) begin
      if (cmd.div_start) neg_ff <= div_num[63];
   end

   gwmc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_mag),
      .divisor  (cmd.div_total ? tot_wgt_ff : rd_wgt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Quotient to a signed, saturated mean.
   logic [35:0]        q_cap;
   logic signed [35:0] mean_val;
   logic signed [35:0] m_ff, o_ff;

   assign q_cap    = (div_q > QCAP) ? 36'(QCAP) : div_q[35:0];
   assign mean_val = sat_v(neg_ff ? -$signed(q_cap) : $signed(q_cap));

   always_ff @(posedge clock) begin
      if (cmd.mean_g_ld) m_ff <= mean_val;
      if (cmd.mean_t_ld) o_ff <= mean_val;
   end

   // Final combination and response register.
   logic               need_total;
   logic signed [35:0] comb_val;

   assign need_total = !between_ff && keep_ff;
   assign comb_val   = between_ff ? m_ff :
                       sat_v(36'(smp_ff) - m_ff + (need_total ? o_ff : 36'sd0));

   logic        rsp_valid_ff;
   logic [31:0] rsp_result_ff;
   logic        rsp_present_ff;
   logic [1:0]  rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_ld;
      end
      if (cmd.rsp_ld) begin
         case (cmd.rsp_kind)
            gwmc_pkg::RSP_FINAL: begin
               rsp_result_ff  <= comb_val[31:0];
               rsp_present_ff <= 1'b1;
               rsp_err_ff     <= gwmc_pkg::ERR_OK;
            end
            gwmc_pkg::RSP_ZERO_TW: begin
               rsp_result_ff  <= '0;
               rsp_present_ff <= 1'b0;
               rsp_err_ff     <= gwmc_pkg::ERR_ZERO_DIV;
            end
            default: begin
               rsp_result_ff  <= '0;
               rsp_present_ff <= 1'b0;
               rsp_err_ff     <= early_err;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_result_present = rsp_present_ff;
   assign rsp_error_code     = rsp_err_ff;

   always_comb begin
      status.action     = act_ff;
      status.g_ok       = g_ok;
      status.clr_last   = (clr_cnt_ff == LAST_ADDR);
      status.early      = err_groups || miss_out || pois_out || zdiv;
      status.need_total = need_total;
      status.tw_zero    = (tot_wgt_ff == 64'd0);
      status.div_done   = div_done;
   end

   // A response lasts one cycle, and an absent result carries zero.
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held longer than one cycle");
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_present_ff) |-> (rsp_result_ff == 32'd0))
      else $error("absent result is not zero");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> ((cmd.div_total ? tot_wgt_ff : rd_wgt_ff) != 64'd0))
      else $error("division started with a zero divisor");

endmodule

/* design/gwmc_ctrl.sv */
module gwmc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  gwmc_pkg::dp_status_type status,
   output gwmc_pkg::ctrl_cmd_type  cmd
);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_DEC  = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_DIVG = 3'd4;
   localparam logic [2:0] S_TCHK = 3'd5;
   localparam logic [2:0] S_DIVT = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0] state_ff, state_in;

   // Sequencing of one item at a time.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rsp_kind = gwmc_pkg::RSP_EARLY;
      case (state_ff)
         S_CLR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_DEC;
            end
         end
         S_DEC: begin
            case (status.action)
               gwmc_pkg::ACT_CLEAR: state_in = S_CLR;
               gwmc_pkg::ACT_ACCUM: begin
                  cmd.mem_rd = 1'b1;
                  state_in   = status.g_ok ? S_EVAL : S_IDLE;
               end
               gwmc_pkg::ACT_XFORM: begin
                  cmd.mem_rd = 1'b1;
                  state_in   = S_EVAL;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_EVAL: begin
            if (status.action == gwmc_pkg::ACT_ACCUM) begin
               cmd.acc_upd = 1'b1;
               state_in    = S_IDLE;
            end else if (status.early) begin
               cmd.rsp_ld = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVG;
            end
         end
         S_DIVG: begin
            if (status.div_done) begin
               cmd.mean_g_ld = 1'b1;
               state_in      = status.need_total ? S_TCHK : S_OUT;
            end
         end
         S_TCHK: begin
            if (status.tw_zero) begin
               cmd.rsp_ld   = 1'b1;
               cmd.rsp_kind = gwmc_pkg::RSP_ZERO_TW;
               state_in     = S_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_total = 1'b1;
               state_in      = S_DIVT;
            end
         end
         S_DIVT: begin
            cmd.div_total = 1'b1;
            if (status.div_done) begin
               cmd.mean_t_ld = 1'b1;
               state_in      = S_OUT;
            end
         end
         S_OUT: begin
            cmd.rsp_ld   = 1'b1;
            cmd.rsp_kind = gwmc_pkg::RSP_FINAL;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // An item is taken only when idle; a response never comes out of a sweep.
   a_latch_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |-> (state_ff == S_IDLE && start))
      else $error("item taken while busy");
   a_sweep_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_wr |-> (!cmd.rsp_ld && !cmd.acc_upd && !cmd.div_start))
      else $error("table sweep overlaps other work");
   a_after_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_ld |=> (state_ff == S_IDLE))
      else $error("controller not idle after response");

endmodule

/* design/grouped_weighted_mean_centering_core.sv */
// Channel  Direction  Handshake                  Payload
// req      in         start & !busy              action, sample, presence flags, weight, group
// rsp      out        rsp_valid, one-cycle pulse result, result_present, error_code
// csr      in         csr_valid & csr_ready      csr_index, csr_wdata
//
// Accumulate, and a transform whose outcome is settled early, pass through S_DEC and S_EVAL
// only; another transform runs the group-mean division, then the overall-mean one if needed.
// Each mean is a 64-by-64-bit division done one quotient bit per cycle in one shared unit.
// A clear item, like reset, sweeps the group tables one entry per cycle, and busy stays high
// meanwhile. Configuration writes are taken at any time. Results cannot be stalled: each
// appears for exactly one cycle.
module grouped_weighted_mean_centering_core #(
   parameter int unsigned MAX_GROUPS = 1024,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_action,
   input  logic [31:0]                       req_sample,
   input  logic                              req_sample_present,
   input  logic [31:0]                       req_weight,
   input  logic                              req_weight_present,
   input  logic [9:0]                        req_group_index,
   output logic                              rsp_valid,
   output logic [31:0]                       rsp_result,
   output logic                              rsp_result_present,
   output logic [1:0]                        rsp_error_code,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gwmc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic                              csr_wdata
);

   gwmc_pkg::ctrl_cmd_type  cmd;
   gwmc_pkg::dp_status_type status;

   gwmc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   gwmc_datapath #(
      .MAX_GROUPS (MAX_GROUPS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_action),
      .req_sample         (req_sample),
      .req_sample_present (req_sample_present),
      .req_weight         (req_weight),
      .req_weight_present (req_weight_present),
      .req_group_index    (req_group_index),
      .rsp_valid          (rsp_valid),
      .rsp_result         (rsp_result),
      .rsp_result_present (rsp_result_present),
      .rsp_error_code     (rsp_error_code),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

endmodule
